// ===== hdl/crcd_pkg.sv =====
`default_nettype none

package crcd_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [7:0]  MARKER_RST = 8'hD8;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_QUERY = 3'd1,
		PH_LEN_L = 3'd2,
		PH_LEN_H = 3'd3,
		PH_DATA  = 3'd4,
		PH_CRC_L = 3'd5,
		PH_CRC_H = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_GOOD    = 2'd2,
		EV_BAD     = 2'd3
	} event_t;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [7:0]  frame_query;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
		event_t      event_kind;
	} result_t;

	// CRC-16, MSB first, one byte folded in
	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/crcd_in_stage.sv =====
`default_nettype none

module crcd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/crcd_parser.sv =====
`default_nettype none

module crcd_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       marker_we,
	input  wire logic [7:0] marker_wdata,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output crcd_pkg::result_t res
);

	crcd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  marker_q;
	logic [7:0]  query_q, query_d;
	logic [15:0] len_q, len_d;
	logic [15:0] seen_q, seen_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_upd;
	logic [15:0] seen_inc;
	crcd_pkg::event_t kind;

	assign crc_upd  = crcd_pkg::crc_fold(crc_q, rx_byte);
	assign seen_inc = seen_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		query_d  = query_q;
		len_d    = len_q;
		seen_d   = seen_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		kind     = crcd_pkg::EV_NONE;
		res.payload_byte  = '0;
		res.payload_index = '0;
		unique case (phase_q)
			crcd_pkg::PH_QUERY: begin
				query_d = rx_byte;
				crc_d   = crc_upd;
				phase_d = crcd_pkg::PH_LEN_L;
			end
			crcd_pkg::PH_LEN_L: begin
				len_d   = {8'h00, rx_byte};
				crc_d   = crc_upd;
				phase_d = crcd_pkg::PH_LEN_H;
			end
			crcd_pkg::PH_LEN_H: begin
				len_d   = {rx_byte, len_q[7:0]};
				crc_d   = crc_upd;
				phase_d = (len_d == 16'd0) ? crcd_pkg::PH_CRC_L : crcd_pkg::PH_DATA;
			end
			crcd_pkg::PH_DATA: begin
				kind              = crcd_pkg::EV_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = seen_q;
				crc_d             = crc_upd;
				seen_d            = seen_inc;
				if (seen_inc >= len_q) begin
					phase_d = crcd_pkg::PH_CRC_L;
				end
			end
			crcd_pkg::PH_CRC_L: begin
				crc_lo_d = rx_byte;
				phase_d  = crcd_pkg::PH_CRC_H;
			end
			crcd_pkg::PH_CRC_H: begin
				kind    = ({rx_byte, crc_lo_q} == crc_q) ? crcd_pkg::EV_GOOD : crcd_pkg::EV_BAD;
				phase_d = crcd_pkg::PH_WAIT;
			end
			default: begin
				// waiting for start; also recovers from an unused phase code
				phase_d = crcd_pkg::PH_WAIT;
				if (rx_byte == marker_q) begin
					query_d = '0;
					len_d   = '0;
					seen_d  = '0;
					crc_d   = crcd_pkg::crc_fold(crcd_pkg::CRC_INIT, rx_byte);
					phase_d = crcd_pkg::PH_QUERY;
				end
			end
		endcase
		res.event_kind   = kind;
		res.frame_query  = query_d;
		res.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= crcd_pkg::MARKER_RST;
		end else if (marker_we) begin
			marker_q <= marker_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= crcd_pkg::PH_WAIT;
			query_q  <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			crc_q    <= crcd_pkg::CRC_INIT;
			crc_lo_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			query_q  <= query_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/crcd_out_stage.sv =====
`default_nettype none

module crcd_out_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire crcd_pkg::result_t res,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,
	output logic [1:0]       m_tuser
);

	crcd_pkg::result_t res_q;

	assign free     = !m_tvalid || m_tready;
	assign m_tdata  = {res_q.frame_length, res_q.frame_query,
	                   res_q.payload_index, res_q.payload_byte};
	assign m_tuser  = res_q.event_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/crc_checked_packet_deframer.sv =====
// Channel   Dir  Handshake                       Contents
// s_axis    in   s_axis_tvalid / s_axis_tready   rx_byte
// m_axis    out  m_axis_tvalid / m_axis_tready   event_kind, payload fields, frame info
// cfg       in   start_marker_we                 start_marker
//
// One result per received byte. A byte passes the input register, then is parsed
// and CRC-folded into the result register; one byte per cycle sustained while
// the output is not stalled, set by the single-byte unrolled CRC-16 update.
// Reset clears the phase to waiting for start, CRC to 0xFFFF, marker to 0xD8.
// A stalled output holds the result; the input register keeps taking bytes
// until both stages are full.
`default_nettype none

module crc_checked_packet_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start_marker_we,
	input  wire logic [7:0]  start_marker_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] payload_byte, [23:8] payload_index, [31:24] frame_query,
	// [47:32] frame_length
	output logic [47:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser   // [1:0] event_kind
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_free;
	logic              adv;
	crcd_pkg::result_t res;

	// a byte moves out of the input register when the result register can take it
	assign adv = valid_s1 && out_free;

	crcd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.take     (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// frame state, running CRC and start marker register
	crcd_parser u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.marker_we    (start_marker_we),
		.marker_wdata (start_marker_wdata),
		.step         (adv),
		.rx_byte      (byte_s1),
		.res          (res)
	);

	crcd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser)
	);

	// a payload index always lies inside the declared length
	a_idx_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == crcd_pkg::EV_PAYLOAD)
		|-> (m_axis_tdata[23:8] < m_axis_tdata[47:32]))
		else $error("payload index beyond frame length");

	// non-payload results carry zero payload fields
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != crcd_pkg::EV_PAYLOAD)
		|-> (m_axis_tdata[23:0] == 24'd0))
		else $error("stray payload fields");

	// an empty input register never holds off the source
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled while empty");

	// a byte in the input register moves on whenever the output is free
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
		else $error("result not loaded");

endmodule

`default_nettype wire
